// ===== sv/kmd_pkg.sv =====
package kmd_pkg;

    localparam int COL_W      = 4;
    localparam int ROW_BITS_W = 8;
    localparam int NOW_W      = 16;
    localparam int KEYS_W     = 16;
    localparam int ROW_IDX_W  = 3;
    localparam int MODE_W     = 2;
    localparam int MS_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int CNT_W      = 7;
    localparam int PRESS_W    = 5;
    localparam int SEC_W      = 3;
    localparam int SEC_ROWS   = 3;
    localparam int PSEUDO_ROWS = 4;
    localparam int F18_BIT    = 13;

    localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;
    localparam logic [SEC_W-1:0] SEC_MAX = 3'd6;

    localparam logic [MODE_W-1:0] CLICK_NONE     = 2'd0;
    localparam logic [MODE_W-1:0] CLICK_SOLENOID = 2'd1;
    localparam logic [MODE_W-1:0] CLICK_BUZZER   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MS    = 2'd2;

    localparam logic [MS_W-1:0] DEBOUNCE_RESET = 8'd2;
    localparam logic [MS_W-1:0] CLICK_RESET    = 8'd50;

    typedef struct packed {
        logic               any_change;
        logic [PRESS_W-1:0] presses;
    } kmd_merge_t;

endpackage

// ===== sv/kmd_lane.sv =====
module kmd_lane #(
    parameter int COLS = 16,
    parameter int ROW  = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [kmd_pkg::COL_W-1:0]  column,
    input  logic                       row_bit,
    output logic [COLS-1:0]            raw,
    output logic                       changed,
    output logic                       counted
);
    import kmd_pkg::*;

    logic [COLS-1:0] raw_reg;
    logic [COLS-1:0] raw_next;
    logic [COLS-1:0] col_bit;
    logic            col_ok;
    logic            pressed;

    assign col_ok  = 32'(column) < COLS;
    assign col_bit = col_ok ? ({{(COLS-1){1'b0}}, 1'b1} << column) : '0;
    assign pressed = col_ok && row_bit;

    always_comb
    begin
        if (pressed)
        begin
            raw_next = raw_reg | col_bit;
        end
        else
        begin
            raw_next = raw_reg & ~col_bit;
        end
    end

    // security bits (top column, rows 0..3) are not counted
    assign changed = raw_next != raw_reg;
    assign counted = pressed && ((32'(column) < COLS - 1) || (ROW > 3));
    assign raw     = raw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg <= '0;
        end
        else if (accept)
        begin
            raw_reg <= raw_next;
        end
    end

endmodule

// ===== sv/kmd_merge.sv =====
module kmd_merge #(
    parameter int ROWS = 8
) (
    input  logic [ROWS-1:0]         changed,
    input  logic [ROWS-1:0]         counted,
    output kmd_pkg::kmd_merge_t     result
);
    import kmd_pkg::*;

    always_comb
    begin
        result.any_change = |changed;
        result.presses    = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            result.presses = result.presses + PRESS_W'(counted[r]);
        end
    end

endmodule

// ===== sv/key_matrix_debounce_click.sv =====
// An accepted end-of-scan sample is registered in eos_reg, which sets busy_reg and
// updates the stable matrix; rows then follow from row 0, one per cycle while out_stall is low.
// Throughput: one column sample per cycle; an end-of-scan sample waits until the
// previous ROWS-row report has drained from the stable-matrix output register.
// Reset (async, active low): matrices, timers, counts and levels clear;
// click mode none, debounce time 2 ms, click time 50 ms.
module key_matrix_debounce_click #(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [kmd_pkg::COL_W-1:0]         column,
    input  logic [kmd_pkg::ROW_BITS_W-1:0]    row_bits,
    input  logic                              end_of_scan,
    input  logic [kmd_pkg::NOW_W-1:0]         now_ms,
    input  logic                              kana_led,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [kmd_pkg::ROW_IDX_W-1:0]     row_index,
    output logic [kmd_pkg::KEYS_W-1:0]        row_keys,
    output logic                              last_row,
    output logic                              solenoid_on,
    output logic                              tone_on,
    input  logic                              cfg_we,
    input  logic [kmd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kmd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import kmd_pkg::*;

    localparam int IDX_W = $clog2(ROWS);
    localparam int TOP   = COLS - 1;

    logic                  accept;
    logic [COLS-1:0]       raw [ROWS];
    logic [ROWS-1:0]       changed;
    logic [ROWS-1:0]       counted;
    logic [ROWS-1:0]       lane_bit;
    kmd_merge_t            mrg;

    logic [MODE_W-1:0]     mode_reg;
    logic [MS_W-1:0]       debounce_reg;
    logic [MS_W-1:0]       click_reg;

    logic [CNT_W-1:0]      cnt_reg, cnt_next, cnt_base;
    logic [CNT_W:0]        cnt_sum;
    logic [CNT_W-1:0]      scnt_reg, scnt_next;
    logic                  chg_pending_reg, chg_pending_next;
    logic [NOW_W-1:0]      chg_stamp_reg, chg_stamp_next;
    logic                  click_pending_reg, click_pending_next;
    logic [NOW_W-1:0]      click_stamp_reg, click_stamp_next;
    logic [SEC_W-1:0]      sec_reg, sec_next;
    logic [SEC_W-1:0]      code;
    logic                  sol_reg, sol_next;
    logic                  tone_reg, tone_next;
    logic [COLS-1:0]       stable_reg [ROWS];
    logic [COLS-1:0]       stable_next [ROWS];

    logic                  eos_reg;
    logic [NOW_W-1:0]      now_reg;
    logic                  kana_reg;
    logic                  fire;
    logic [NOW_W-1:0]      deb_elapsed;
    logic [NOW_W-1:0]      click_elapsed;

    logic                  busy_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  last_xfer;

    assign last_xfer = busy_reg && !out_stall && (idx_reg == IDX_W'(ROWS - 1));
    assign in_stall  = end_of_scan && (eos_reg || (busy_reg && !last_xfer));
    assign accept    = in_valid && !in_stall;

    for (genvar r = 0; r < ROWS; r++)
    begin : g_lane
        if (r < ROW_BITS_W)
        begin : g_sensed
            assign lane_bit[r] = row_bits[r];
        end
        else
        begin : g_released
            assign lane_bit[r] = 1'b0;
        end

        kmd_lane #(
            .COLS (COLS),
            .ROW  (r)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .accept  (accept),
            .column  (column),
            .row_bit (lane_bit[r]),
            .raw     (raw[r]),
            .changed (changed[r]),
            .counted (counted[r])
        );
    end

    kmd_merge #(
        .ROWS (ROWS)
    ) u_merge (
        .changed (changed),
        .counted (counted),
        .result  (mrg)
    );

    // scan count restarts in the end-of-scan stage
    assign cnt_base = eos_reg ? '0 : cnt_reg;
    assign cnt_sum  = {1'b0, cnt_base} + (CNT_W+1)'(mrg.presses);

    always_comb
    begin
        if (!accept)
        begin
            cnt_next = cnt_base;
        end
        else if (cnt_sum > {1'b0, CNT_MAX})
        begin
            cnt_next = CNT_MAX;
        end
        else
        begin
            cnt_next = cnt_sum[CNT_W-1:0];
        end
    end

    assign deb_elapsed = now_reg - chg_stamp_reg;
    assign fire = eos_reg && chg_pending_reg && (deb_elapsed >= NOW_W'(debounce_reg));

    assign chg_pending_next = (accept && mrg.any_change) ? 1'b1 :
                              (fire ? 1'b0 : chg_pending_reg);
    assign chg_stamp_next   = (accept && mrg.any_change) ? now_ms : chg_stamp_reg;

    // stable matrix and security pseudo keys
    always_comb
    begin
        stable_next = stable_reg;
        sec_next    = sec_reg;
        for (int i = 0; i < SEC_ROWS; i++)
        begin
            code[i] = ~raw[i][TOP];
        end
        if (fire)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                stable_next[r] = raw[r];
            end
            for (int r = 0; r < PSEUDO_ROWS; r++)
            begin
                stable_next[r][TOP] = 1'b0;
            end
            if (sec_reg == '0 && code != '0 && code <= SEC_MAX)
            begin
                for (int r = 0; r < ROWS; r++)
                begin
                    if (r == int'(code) - 1)
                    begin
                        stable_next[r][TOP] = 1'b1;
                    end
                end
            end
            else if (sec_reg != '0 && sec_reg <= SEC_MAX && code == '0)
            begin
                stable_next[0][F18_BIT] = 1'b1;
                for (int r = 0; r < ROWS; r++)
                begin
                    if (r == int'(sec_reg) - 1)
                    begin
                        stable_next[r][TOP] = 1'b1;
                    end
                end
            end
            sec_next = code;
        end
        else if (eos_reg)
        begin
            stable_next[0][F18_BIT] = 1'b0;
            for (int r = 0; r < PSEUDO_ROWS; r++)
            begin
                stable_next[r][TOP] = 1'b0;
            end
        end
    end

    // click feedback
    always_comb
    begin
        sol_next           = sol_reg;
        tone_next          = tone_reg;
        click_pending_next = click_pending_reg;
        click_stamp_next   = click_stamp_reg;
        scnt_next          = scnt_reg;
        if (fire)
        begin
            case (mode_reg)
                CLICK_SOLENOID:
                begin
                    if (cnt_reg > CNT_W'(1) || (cnt_reg == CNT_W'(1) && scnt_reg > CNT_W'(1)))
                    begin
                        sol_next           = 1'b0;
                        click_stamp_next   = now_reg;
                        click_pending_next = 1'b1;
                    end
                    else
                    begin
                        sol_next = cnt_reg != '0;
                    end
                end
                CLICK_BUZZER:
                begin
                    if (cnt_reg > scnt_reg)
                    begin
                        tone_next          = 1'b1;
                        click_stamp_next   = now_reg;
                        click_pending_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            scnt_next = cnt_reg;
        end
        click_elapsed = now_reg - click_stamp_next;
        if (eos_reg && click_pending_next && click_elapsed >= NOW_W'(click_reg))
        begin
            case (mode_reg)
                CLICK_SOLENOID:
                begin
                    sol_next = 1'b1;
                end
                CLICK_BUZZER:
                begin
                    if (!kana_reg)
                    begin
                        tone_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            click_pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg  <= now_ms;
            kana_reg <= kana_led;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= CLICK_NONE;
            debounce_reg      <= DEBOUNCE_RESET;
            click_reg         <= CLICK_RESET;
            cnt_reg           <= '0;
            scnt_reg          <= '0;
            chg_pending_reg   <= 1'b0;
            chg_stamp_reg     <= '0;
            click_pending_reg <= 1'b0;
            click_stamp_reg   <= '0;
            sec_reg           <= '0;
            sol_reg           <= 1'b0;
            tone_reg          <= 1'b0;
            eos_reg           <= 1'b0;
            busy_reg          <= 1'b0;
            idx_reg           <= '0;
            for (int r = 0; r < ROWS; r++)
            begin
                stable_reg[r] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CLICK_MODE:  mode_reg     <= cfg_data[MODE_W-1:0];
                    CFG_DEBOUNCE_MS: debounce_reg <= cfg_data[MS_W-1:0];
                    CFG_CLICK_MS:    click_reg    <= cfg_data[MS_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            cnt_reg           <= cnt_next;
            scnt_reg          <= scnt_next;
            chg_pending_reg   <= chg_pending_next;
            chg_stamp_reg     <= chg_stamp_next;
            click_pending_reg <= click_pending_next;
            click_stamp_reg   <= click_stamp_next;
            sec_reg           <= sec_next;
            sol_reg           <= sol_next;
            tone_reg          <= tone_next;
            stable_reg        <= stable_next;
            eos_reg           <= accept && end_of_scan;
            if (eos_reg)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (busy_reg && !out_stall)
            begin
                if (idx_reg == IDX_W'(ROWS - 1))
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
        end
    end

    assign out_valid   = busy_reg;
    assign row_index   = ROW_IDX_W'(idx_reg);
    assign row_keys    = KEYS_W'(stable_reg[idx_reg]);
    assign last_row    = idx_reg == IDX_W'(ROWS - 1);
    assign solenoid_on = sol_reg;
    assign tone_on     = tone_reg;

endmodule

// ===== sv/kmd_check.sv =====
module kmd_check (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [kmd_pkg::ROW_IDX_W-1:0]     row_index,
    input logic                              last_row,
    input logic                              solenoid_on,
    input logic                              tone_on
);
    import kmd_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> row_index == '0)
        else $error("report does not start at row 0");

    a_next_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_row |=>
            out_valid && row_index == ROW_IDX_W'($past(row_index) + 1'b1))
        else $error("report rows out of sequence");

    a_report_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_row |=> !out_valid)
        else $error("result after final row transfer");

    a_levels_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_row |=> $stable(solenoid_on) && $stable(tone_on))
        else $error("click levels changed inside a report");

endmodule

bind key_matrix_debounce_click kmd_check u_kmd_check (.*);

// ===== dv/key_matrix_debounce_click_checker.sv =====
module key_matrix_debounce_click_checker #(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [kmd_pkg::COL_W-1:0]         column,
    input  logic [kmd_pkg::ROW_BITS_W-1:0]    row_bits,
    input  logic                              end_of_scan,
    input  logic [kmd_pkg::NOW_W-1:0]         now_ms,
    input  logic                              kana_led,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [kmd_pkg::ROW_IDX_W-1:0]     row_index,
    input  logic [kmd_pkg::KEYS_W-1:0]        row_keys,
    input  logic                              last_row,
    input  logic                              solenoid_on,
    input  logic                              tone_on,
    input  logic                              cfg_we,
    input  logic [kmd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kmd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                fail_count,
    output int                                rows_owed
);
    import kmd_pkg::*;

    localparam int TOP = COLS - 1;

    typedef struct packed {
        logic [ROW_IDX_W-1:0] index;
        logic [KEYS_W-1:0]    keys;
        logic                 last;
        logic                 solenoid;
        logic                 tone;
    } row_report_t;

    row_report_t rows_due[$];

    logic [MODE_W-1:0] click_mode;
    logic [MS_W-1:0]   debounce_time;
    logic [MS_W-1:0]   click_time;
    logic [KEYS_W-1:0] raw_m [ROWS];
    logic [KEYS_W-1:0] stable_m [ROWS];
    logic              change_seen;
    logic [NOW_W-1:0]  change_at;
    logic              click_armed;
    logic [NOW_W-1:0]  click_at;
    logic [CNT_W-1:0]  scan_presses;
    logic [CNT_W-1:0]  stable_presses;
    logic [SEC_W-1:0]  last_code;
    logic              solenoid_lvl;
    logic              tone_lvl;

    function automatic void drop_pseudo_keys();
        for (int i = 0; i < PSEUDO_ROWS; i++)
        begin
            stable_m[i][TOP] = 1'b0;
        end
    endfunction

    function automatic void settle_matrix(input logic [NOW_W-1:0] now);
        logic [CNT_W-1:0] cnt;
        logic [SEC_W-1:0] code;
        cnt = scan_presses;
        if (click_mode == CLICK_SOLENOID)
        begin
            if (cnt > 1 || (cnt == 1 && stable_presses > 1))
            begin
                solenoid_lvl = 1'b0;
                click_at     = now;
                click_armed  = 1'b1;
            end
            else
            begin
                solenoid_lvl = (cnt != 0);
            end
        end
        else if (click_mode == CLICK_BUZZER)
        begin
            if (cnt > stable_presses)
            begin
                tone_lvl    = 1'b1;
                click_at    = now;
                click_armed = 1'b1;
            end
        end
        for (int r = 0; r < ROWS; r++)
        begin
            stable_m[r] = raw_m[r];
        end
        stable_presses = cnt;
        code = '0;
        for (int i = 0; i < SEC_ROWS; i++)
        begin
            code[i] = ~stable_m[i][TOP];
        end
        drop_pseudo_keys();
        if (last_code == 0 && code != 0 && code <= SEC_MAX)
        begin
            stable_m[code - 1][TOP] = 1'b1;
        end
        else if (last_code != 0 && last_code <= SEC_MAX && code == 0)
        begin
            stable_m[0][F18_BIT]         = 1'b1;
            stable_m[last_code - 1][TOP] = 1'b1;
        end
        last_code   = code;
        change_seen = 1'b0;
    endfunction

    function automatic void take_sample(
        input logic [COL_W-1:0]      col,
        input logic [ROW_BITS_W-1:0] bits,
        input logic                  eos,
        input logic [NOW_W-1:0]      now,
        input logic                  kana
    );
        logic [KEYS_W-1:0] cb;
        logic [KEYS_W-1:0] prev;
        logic [NOW_W-1:0]  gap;
        row_report_t       rep;
        cb = KEYS_W'(1) << col;
        for (int r = 0; r < ROWS; r++)
        begin
            prev = raw_m[r];
            if (r < ROW_BITS_W && bits[r])
            begin
                raw_m[r] = prev | cb;
                if ((col != COLS - 1 || r >= PSEUDO_ROWS) && scan_presses != CNT_MAX)
                    scan_presses = scan_presses + 1'b1;
            end
            else
            begin
                raw_m[r] = prev & ~cb;
            end
            if (raw_m[r] != prev)
            begin
                change_at   = now;
                change_seen = 1'b1;
            end
        end
        if (!eos)
            return;

        gap = now - change_at;
        if (change_seen && gap >= debounce_time)
        begin
            settle_matrix(now);
        end
        else
        begin
            stable_m[0][F18_BIT] = 1'b0;
            drop_pseudo_keys();
        end

        gap = now - click_at;
        if (click_armed && gap >= click_time)
        begin
            if (click_mode == CLICK_SOLENOID)
                solenoid_lvl = 1'b1;
            else if (click_mode == CLICK_BUZZER && !kana)
                tone_lvl = 1'b0;
            click_armed = 1'b0;
        end
        scan_presses = '0;

        for (int r = 0; r < ROWS; r++)
        begin
            rep.index    = ROW_IDX_W'(r);
            rep.keys     = stable_m[r];
            rep.last     = (r == ROWS - 1);
            rep.solenoid = solenoid_lvl;
            rep.tone     = tone_lvl;
            rows_due.push_back(rep);
        end
    endfunction

    function automatic void check_row();
        row_report_t want;
        if (rows_due.size() == 0)
        begin
            $error("row %0d transfer with no report outstanding", row_index);
            fail_count++;
            return;
        end
        want = rows_due.pop_front();
        if (row_index !== want.index)
        begin
            $error("row_index: expected %0d, got %0d", want.index, row_index);
            fail_count++;
        end
        if (row_keys !== want.keys)
        begin
            $error("row_keys: expected %h, got %h", want.keys, row_keys);
            fail_count++;
        end
        if (last_row !== want.last)
        begin
            $error("last_row: expected %b, got %b", want.last, last_row);
            fail_count++;
        end
        if (solenoid_on !== want.solenoid)
        begin
            $error("solenoid_on: expected %b, got %b", want.solenoid, solenoid_on);
            fail_count++;
        end
        if (tone_on !== want.tone)
        begin
            $error("tone_on: expected %b, got %b", want.tone, tone_on);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            click_mode     = CLICK_NONE;
            debounce_time  = DEBOUNCE_RESET;
            click_time     = CLICK_RESET;
            for (int r = 0; r < ROWS; r++)
            begin
                raw_m[r]    = '0;
                stable_m[r] = '0;
            end
            change_seen    = 1'b0;
            change_at      = '0;
            click_armed    = 1'b0;
            click_at       = '0;
            scan_presses   = '0;
            stable_presses = '0;
            last_code      = '0;
            solenoid_lvl   = 1'b0;
            tone_lvl       = 1'b0;
            rows_due.delete();
            rows_owed <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_row();
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CLICK_MODE:  click_mode    = cfg_data[MODE_W-1:0];
                    CFG_DEBOUNCE_MS: debounce_time = cfg_data;
                    CFG_CLICK_MS:    click_time    = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                take_sample(column, row_bits, end_of_scan, now_ms, kana_led);
            rows_owed <= rows_due.size();
        end
    end

endmodule

// ===== dv/key_matrix_debounce_click_tb.sv =====
module key_matrix_debounce_click_tb;
    import kmd_pkg::*;

    localparam logic [MODE_W-1:0] CLICK_SPARE = 2'd3;
    localparam int LIMIT       = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 6;
    localparam int NCOLS       = 16;
    localparam int LAST_COL    = NCOLS - 1;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [COL_W-1:0]      column      = '0;
    logic [ROW_BITS_W-1:0] row_bits    = '0;
    logic                  end_of_scan = 1'b0;
    logic [NOW_W-1:0]      now_ms      = '0;
    logic                  kana_led    = 1'b0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [ROW_IDX_W-1:0]  row_index;
    logic [KEYS_W-1:0]     row_keys;
    logic                  last_row;
    logic                  solenoid_on;
    logic                  tone_on;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    int fail_count;
    int rows_owed;
    int cycles    = 0;
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int stride    = 4;
    int sent      = 0;
    logic hold_go = 1'b0;

    logic [ROW_BITS_W-1:0] held [NCOLS];
    logic [SEC_W-1:0]      sec_code = '0;
    logic [NOW_W-1:0]      clock_ms = '0;

    key_matrix_debounce_click dut (.*);

    key_matrix_debounce_click_checker scoreboard (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    initial
    begin
        wait (cycles == LIMIT);
        $display("FAILURE");
        $finish;
    end

    // receiver: random stall, or a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_go)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send(
        input logic [COL_W-1:0]      c,
        input logic [ROW_BITS_W-1:0] b,
        input logic                  e,
        input logic [NOW_W-1:0]      t,
        input logic                  k
    );
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        column      <= c;
        row_bits    <= b;
        end_of_scan <= e;
        now_ms      <= t;
        kana_led    <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (rows_owed != 0);
    endtask

    task automatic write_config(
        input logic [MODE_W-1:0] mode,
        input logic [MS_W-1:0]   deb,
        input logic [MS_W-1:0]   ck
    );
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CLICK_MODE;
        cfg_data  <= CFG_DATA_W'(mode);
        @(posedge clk);
        cfg_index <= CFG_DEBOUNCE_MS;
        cfg_data  <= deb;
        @(posedge clk);
        cfg_index <= CFG_CLICK_MS;
        cfg_data  <= ck;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic play_scan();
        int c;
        int first;
        int len;
        logic [ROW_BITS_W-1:0] b;
        if ($urandom_range(0, 19) == 0)
            clock_ms += NOW_W'($urandom_range(0, 65535));
        else
            clock_ms += NOW_W'($urandom_range(0, stride));
        if ($urandom_range(0, 2) == 0)
        begin
            c = $urandom_range(0, LAST_COL);
            held[c] ^= ROW_BITS_W'(1) << $urandom_range(0, ROW_BITS_W - 1);
        end
        if ($urandom_range(0, 19) == 0)
        begin
            c = $urandom_range(0, LAST_COL);
            held[c] = ROW_BITS_W'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 19) == 0)
        begin
            for (int i = 0; i < NCOLS; i++)
                held[i] = '0;
        end
        if ($urandom_range(0, 9) == 0)
            sec_code = SEC_W'($urandom_range(0, 7));
        held[LAST_COL][SEC_ROWS-1:0] = ~sec_code;

        if ($urandom_range(0, 4) == 0)
        begin
            first = 0;
            len   = NCOLS;
        end
        else
        begin
            len = $urandom_range(1, 4);
            if ($urandom_range(0, 4) < 3)
                first = NCOLS - len;
            else
                first = $urandom_range(0, NCOLS - len);
        end

        for (int i = 0; i < len; i++)
        begin
            b = held[first + i];
            if ($urandom_range(0, 9) == 0)
                b ^= ROW_BITS_W'(1) << $urandom_range(0, ROW_BITS_W - 1);
            send(COL_W'(first + i), b, i == len - 1, clock_ms, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic play_noise();
        clock_ms += NOW_W'($urandom_range(0, 2));
        send(COL_W'($urandom_range(0, LAST_COL)), ROW_BITS_W'($urandom_range(0, 255)),
             $urandom_range(0, 3) == 0, clock_ms, 1'($urandom_range(0, 1)));
    endtask

    task automatic run_random(input int count);
        int stop;
        stop = sent + count;
        while (sent < stop)
        begin
            if ($urandom_range(0, 9) < 7)
                play_scan();
            else
                play_noise();
        end
    endtask

    task automatic run_phase(
        input logic [MODE_W-1:0] mode,
        input logic [MS_W-1:0]   deb,
        input logic [MS_W-1:0]   ck,
        input int                idle,
        input int                stall,
        input int                str,
        input int                count
    );
        drain();
        repeat (SETTLE) @(posedge clk);
        write_config(mode, deb, ck);
        idle_pct  = idle;
        stall_pct = stall;
        stride    = str;
        run_random(count);
    endtask

    initial
    begin
        for (int i = 0; i < NCOLS; i++)
            held[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty report, then press count saturation
        send(4'd0, 8'h00, 1'b1, 16'h0000, 1'b0);
        for (int c = 0; c < LAST_COL; c++)
            send(COL_W'(c), 8'hFF, 1'b0, 16'd100, 1'b1);
        send(4'd3, 8'hFF, 1'b0, 16'd100, 1'b0);
        send(4'd15, 8'hFF, 1'b1, 16'hFFFF, 1'b1);
        // security key: insert, then removal with the F18 key, then code seven
        send(4'd15, 8'hFA, 1'b1, 16'h0001, 1'b0);
        send(4'd15, 8'hFA, 1'b1, 16'h0003, 1'b0);
        send(4'd15, 8'hFF, 1'b1, 16'h0010, 1'b1);
        send(4'd15, 8'hFF, 1'b1, 16'h0012, 1'b0);
        send(4'd15, 8'hF8, 1'b1, 16'h0020, 1'b0);
        send(4'd15, 8'hF8, 1'b1, 16'h0030, 1'b1);
        clock_ms = 16'h0030;
        run_random(40);

        run_phase(CLICK_SOLENOID, 8'd0, 8'd0, 55, 0, 3, 57);
        run_phase(CLICK_BUZZER, 8'd255, 8'd255, 0, 55, 400, 57);
        run_phase(CLICK_SPARE, MS_W'($urandom_range(0, 255)), MS_W'($urandom_range(0, 255)),
                  19, 19, 8, 57);

        run_phase(CLICK_SOLENOID, 8'd4, 8'd10, 0, 0, 4, 25);
        in_valid <= 1'b0;
        hold_go  <= 1'b1;
        @(posedge clk);
        hold_go  <= 1'b0;
        run_random(35);
        drain();
        run_random(20);

        run_phase(CLICK_BUZZER, 8'd1, 8'd6, 19, 19, 3, 57);
        run_phase(CLICK_NONE, 8'd0, 8'd255, 55, 55, 5, 50);

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
